// ----- hw/rtl/median_filter_3x3_unit_defines.svh -----
// Assertion macros used by the checker of the 3x3 median filter.
`ifndef MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH
`define MEDIAN_FILTER_3X3_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define MF3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mf3_pkg.sv -----
// Shared constants and types of the 3x3 median filter.
package mf3_pkg;

    // Line store depth and derived widths
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int EW_W         = $clog2(MAX_WIDTH + 1);
    localparam int PEND_W       = $clog2(MAX_WIDTH + 2);

    // Register and field widths
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 1;
    localparam int CHAN_W       = 8;
    localparam int GRAY_W       = 8;
    localparam int WIN_TAPS     = 9;
    localparam int TAP_IDX_W    = $clog2(WIN_TAPS);

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd28;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd28;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef logic [GRAY_W-1:0] gray_t;
    typedef gray_t [WIN_TAPS-1:0] window_t;

    // Pixel on its way to the output, with its border/interior decision
    typedef struct packed {
        logic   valid;
        logic   interior;
        logic   eof;
        pixel_t pix;
    } emit_t;

    typedef struct packed {
        logic   eof;
        pixel_t pix;
    } out_item_t;

endpackage

// ----- hw/rtl/median_filter_3x3_unit.sv -----
// Top level of the 3x3 median filter over an RGB raster stream.
//
//  channel   ports                                   direction  handshake
//  request   s_opcode s_red s_green s_blue           in         s_valid / s_ready
//  result    m_out_red m_out_green m_out_blue        out        m_valid / m_ready
//            m_end_of_frame
//  config    cfg_wr_index cfg_wr_data                in         cfg_wr_en, no wait
//
// One request is taken every cycle while the output queue has room; a released result
// passes the line store read, window update, two sorting stages and the output queue.
// Each line store does one read and one write per cycle, with forwarding between them.
// The line stores come out of reset uninitialized; there is no clearing pass.
// s_ready drops only while two results wait in the output queue.
module median_filter_3x3_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_opcode,
    input  logic [mf3_pkg::CHAN_W-1:0]      s_red,
    input  logic [mf3_pkg::CHAN_W-1:0]      s_green,
    input  logic [mf3_pkg::CHAN_W-1:0]      s_blue,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mf3_pkg::CHAN_W-1:0]      m_out_red,
    output logic [mf3_pkg::CHAN_W-1:0]      m_out_green,
    output logic [mf3_pkg::CHAN_W-1:0]      m_out_blue,
    output logic                            m_end_of_frame,
    input  logic                            cfg_wr_en,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int COL_W  = mf3_pkg::COL_W;
    localparam int EW_W   = mf3_pkg::EW_W;
    localparam int PEND_W = mf3_pkg::PEND_W;
    localparam int HR_W   = mf3_pkg::HEIGHT_REG_W;

    // Configuration
    logic [mf3_pkg::WIDTH_REG_W-1:0] width_reg;
    logic [HR_W-1:0]                 height_reg;
    logic [EW_W-1:0]                 eff_w;
    logic [HR_W-1:0]                 eff_h;
    logic                            small_frame;

    // Frame position
    logic [COL_W-1:0]  ic_reg, ic_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [COL_W-1:0]  oc_reg, oc_next;
    logic [HR_W-1:0]   orow_reg, orow_next;

    // Request decode
    logic              en;
    logic              accept;
    logic              is_flush;
    logic              is_pix;
    logic              send_full;
    logic              emit_now;
    logic              interior_now;
    logic              eof_now;
    logic [COL_W-1:0]  mid_addr;
    logic [PEND_W:0]   addr_a, addr_k, addr_diff;
    mf3_pkg::pixel_t   in_pix;

    // Read stage
    logic              s1_pix_reg;
    logic              s1_emit_reg;
    logic              s1_interior_reg;
    logic              s1_eof_reg;
    logic              s1_use_prev_reg;
    mf3_pkg::pixel_t   s1_rgb_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              fwd_up_reg, fwd_mid_reg;
    mf3_pkg::pixel_t   fwd_up_data_reg, fwd_mid_data_reg;
    mf3_pkg::pixel_t   up_rdata, mid_rdata;
    mf3_pkg::pixel_t   s1_top, s1_mid;
    mf3_pkg::pixel_t   prev_mid_reg;
    logic              s1_we;
    mf3_pkg::emit_t    s1_side;

    // Window stage and output
    mf3_pkg::window_t  window_reg, window_next;
    mf3_pkg::emit_t    s2_side_reg;
    mf3_pkg::gray_t    med;
    mf3_pkg::emit_t    med_side;
    mf3_pkg::out_item_t q_item, q_head;
    logic              q_full;
    logic              q_not_empty;

    function automatic mf3_pkg::gray_t gray_of(mf3_pkg::pixel_t p);
        logic [12:0] sum;
        sum = 13'(p.red) * 13'd11 + {1'b0, p.green, 4'b0000} + 13'(p.blue) * 13'd5;
        return sum[12:5];
    endfunction

    // Hold the frame size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mf3_pkg::WIDTH_RESET;
            height_reg <= mf3_pkg::HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (mf3_pkg::cfg_index_t'(cfg_wr_index))
                mf3_pkg::CFG_FRAME_WIDTH: begin
                    width_reg <= cfg_wr_data[mf3_pkg::WIDTH_REG_W-1:0];
                end
                mf3_pkg::CFG_FRAME_HEIGHT: begin
                    height_reg <= cfg_wr_data[HR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame size
    always_comb begin
        if (width_reg == '0) begin
            eff_w = EW_W'(1);
        end else if (32'(width_reg) > 32'(mf3_pkg::MAX_WIDTH)) begin
            eff_w = EW_W'(mf3_pkg::MAX_WIDTH);
        end else begin
            eff_w = EW_W'(width_reg);
        end
        eff_h       = (height_reg == '0) ? HR_W'(1) : height_reg;
        small_frame = (eff_w < EW_W'(3)) || (eff_h < HR_W'(3));
    end

    // Decode the request
    assign en        = !q_full;
    assign s_ready   = en;
    assign accept    = s_valid && s_ready;
    assign is_flush  = (mf3_pkg::opcode_t'(s_opcode) == mf3_pkg::OP_FLUSH);
    assign is_pix    = accept && !is_flush;
    assign send_full = (pend_reg >= PEND_W'(eff_w) + 1'b1);
    assign emit_now  = accept && (is_flush ? (pend_reg != '0) : send_full);
    assign in_pix    = '{red: s_red, green: s_green, blue: s_blue};

    // Border decision for the pixel that leaves next
    always_comb begin
        interior_now = !is_flush && !small_frame &&
                       (orow_reg >= HR_W'(1)) && (orow_reg <= eff_h - HR_W'(2)) &&
                       (oc_reg >= COL_W'(1)) && (EW_W'(oc_reg) <= eff_w - EW_W'(2));
        eof_now      = (orow_reg == eff_h - HR_W'(1)) && (EW_W'(oc_reg) == eff_w - EW_W'(1));
    end

    // Middle store address of the oldest pending pixel on a flush
    always_comb begin
        addr_a = (PEND_W+1)'(ic_reg);
        addr_k = (PEND_W+1)'(pend_reg);
        if (addr_a >= addr_k) begin
            addr_diff = addr_a - addr_k;
        end else begin
            addr_diff = addr_a + (PEND_W+1)'(eff_w) - addr_k;
        end
        mid_addr = is_flush ? COL_W'(addr_diff) : ic_reg;
    end

    // Advance input and output positions
    always_comb begin
        ic_next   = ic_reg;
        pend_next = pend_reg;
        oc_next   = oc_reg;
        orow_next = orow_reg;
        if (cfg_wr_en) begin
            ic_next   = '0;
            pend_next = '0;
            oc_next   = '0;
            orow_next = '0;
        end else if (accept) begin
            if (!is_flush) begin
                ic_next = (EW_W'(ic_reg) == eff_w - 1'b1) ? '0 : ic_reg + 1'b1;
                if (!send_full) begin
                    pend_next = pend_reg + 1'b1;
                end
            end else if (pend_reg != '0) begin
                pend_next = pend_reg - 1'b1;
            end
            if (emit_now) begin
                if (EW_W'(oc_reg) == eff_w - 1'b1) begin
                    oc_next   = '0;
                    orow_next = (orow_reg == eff_h - 1'b1) ? '0 : orow_reg + 1'b1;
                end else begin
                    oc_next = oc_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ic_reg   <= '0;
            pend_reg <= '0;
            oc_reg   <= '0;
            orow_reg <= '0;
        end else begin
            ic_reg   <= ic_next;
            pend_reg <= pend_next;
            oc_reg   <= oc_next;
            orow_reg <= orow_next;
        end
    end

    // Line stores: upper takes the old middle row, middle takes the new pixel
    mf3_line_ram #(
        .DATA_W ($bits(mf3_pkg::pixel_t)),
        .DEPTH  (mf3_pkg::MAX_WIDTH)
    ) u_upper_ram (
        .aclk    (aclk),
        .wr_en   (s1_we),
        .wr_addr (s1_col_reg),
        .wr_data (s1_mid),
        .rd_en   (en),
        .rd_addr (ic_reg),
        .rd_data (up_rdata)
    );

    mf3_line_ram #(
        .DATA_W ($bits(mf3_pkg::pixel_t)),
        .DEPTH  (mf3_pkg::MAX_WIDTH)
    ) u_middle_ram (
        .aclk    (aclk),
        .wr_en   (s1_we),
        .wr_addr (s1_col_reg),
        .wr_data (s1_rgb_reg),
        .rd_en   (en),
        .rd_addr (mid_addr),
        .rd_data (mid_rdata)
    );

    // Read stage: resolve forwarded data and pick the emitted pixel
    always_comb begin
        s1_top       = fwd_up_reg  ? fwd_up_data_reg  : up_rdata;
        s1_mid       = fwd_mid_reg ? fwd_mid_data_reg : mid_rdata;
        s1_we        = en && s1_pix_reg;
        s1_side.valid    = s1_emit_reg;
        s1_side.interior = s1_interior_reg;
        s1_side.eof      = s1_eof_reg;
        s1_side.pix      = s1_use_prev_reg ? prev_mid_reg : s1_mid;
    end

    // Window shift: drop the oldest column, append the new one
    always_comb begin
        window_next = window_reg;
        for (int r = 0; r < 3; r++) begin
            window_next[3*r]   = window_reg[3*r+1];
            window_next[3*r+1] = window_reg[3*r+2];
        end
        window_next[2] = gray_of(s1_top);
        window_next[5] = gray_of(s1_mid);
        window_next[8] = gray_of(s1_rgb_reg);
    end

    // Pipeline control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_pix_reg  <= 1'b0;
            s1_emit_reg <= 1'b0;
            fwd_up_reg  <= 1'b0;
            fwd_mid_reg <= 1'b0;
            s2_side_reg <= '0;
            window_reg  <= '0;
        end else begin
            if (en) begin
                s1_pix_reg  <= is_pix;
                s1_emit_reg <= emit_now;
                fwd_up_reg  <= s1_we && (ic_reg == s1_col_reg);
                fwd_mid_reg <= s1_we && (mid_addr == s1_col_reg);
                s2_side_reg <= s1_side;
            end
            if (cfg_wr_en) begin
                window_reg <= '0;
            end else if (s1_we) begin
                window_reg <= window_next;
            end
        end
    end

    // Pipeline payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_interior_reg  <= interior_now;
            s1_eof_reg       <= eof_now;
            s1_use_prev_reg  <= !is_flush || send_full;
            s1_rgb_reg       <= in_pix;
            s1_col_reg       <= ic_reg;
            fwd_up_data_reg  <= s1_mid;
            fwd_mid_data_reg <= s1_rgb_reg;
        end
        if (s1_we) begin
            prev_mid_reg <= s1_mid;
        end
    end

    mf3_median9 u_median9 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .win_in   (window_reg),
        .side_in  (s2_side_reg),
        .med_out  (med),
        .side_out (med_side)
    );

    // Replace interior pixels by the median gray
    always_comb begin
        q_item.eof = med_side.eof;
        if (med_side.interior) begin
            q_item.pix = '{red: med, green: med, blue: med};
        end else begin
            q_item.pix = med_side.pix;
        end
    end

    mf3_out_queue u_out_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && med_side.valid),
        .push_item (q_item),
        .pop       (m_valid && m_ready),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    assign m_valid        = q_not_empty;
    assign m_out_red      = q_head.pix.red;
    assign m_out_green    = q_head.pix.green;
    assign m_out_blue     = q_head.pix.blue;
    assign m_end_of_frame = q_head.eof;

endmodule

// ----- hw/rtl/mf3_line_ram.sv -----
// Simple dual-port line store RAM with one registered read port.
module mf3_line_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/mf3_median9.sv -----
// Pipelined median-of-nine sorting network with a sideband that follows the data.
module mf3_median9 (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  mf3_pkg::window_t win_in,
    input  mf3_pkg::emit_t   side_in,
    output mf3_pkg::gray_t   med_out,
    output mf3_pkg::emit_t   side_out
);

    mf3_pkg::window_t sta_reg, sta_next;
    mf3_pkg::window_t stb_reg, stb_next;
    mf3_pkg::window_t stc;
    mf3_pkg::emit_t   side_a_reg;
    mf3_pkg::emit_t   side_b_reg;

    // Compare-exchange: lower value to tap a, higher to tap b
    function automatic mf3_pkg::window_t cas(mf3_pkg::window_t v,
                                             logic [mf3_pkg::TAP_IDX_W-1:0] a,
                                             logic [mf3_pkg::TAP_IDX_W-1:0] b);
        mf3_pkg::window_t r;
        r = v;
        if (v[a] > v[b]) begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    // Sort each group of three
    always_comb begin
        sta_next = win_in;
        sta_next = cas(sta_next, 4'd1, 4'd2);
        sta_next = cas(sta_next, 4'd4, 4'd5);
        sta_next = cas(sta_next, 4'd7, 4'd8);
        sta_next = cas(sta_next, 4'd0, 4'd1);
        sta_next = cas(sta_next, 4'd3, 4'd4);
        sta_next = cas(sta_next, 4'd6, 4'd7);
        sta_next = cas(sta_next, 4'd1, 4'd2);
        sta_next = cas(sta_next, 4'd4, 4'd5);
        sta_next = cas(sta_next, 4'd7, 4'd8);
    end

    // Cross the groups
    always_comb begin
        stb_next = sta_reg;
        stb_next = cas(stb_next, 4'd0, 4'd3);
        stb_next = cas(stb_next, 4'd5, 4'd8);
        stb_next = cas(stb_next, 4'd4, 4'd7);
        stb_next = cas(stb_next, 4'd3, 4'd6);
        stb_next = cas(stb_next, 4'd1, 4'd4);
        stb_next = cas(stb_next, 4'd2, 4'd5);
        stb_next = cas(stb_next, 4'd4, 4'd7);
    end

    // Final selection of the middle value
    always_comb begin
        stc = stb_reg;
        stc = cas(stc, 4'd4, 4'd2);
        stc = cas(stc, 4'd6, 4'd4);
        stc = cas(stc, 4'd4, 4'd2);
    end

    assign med_out  = stc[4];
    assign side_out = side_b_reg;

    // Advance the sideband with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_a_reg <= '0;
            side_b_reg <= '0;
        end else if (en) begin
            side_a_reg <= side_in;
            side_b_reg <= side_a_reg;
        end
    end

    // Advance the sorting stages
    always_ff @(posedge aclk) begin
        if (en) begin
            sta_reg <= sta_next;
            stb_reg <= stb_next;
        end
    end

endmodule

// ----- hw/rtl/mf3_out_queue.sv -----
// Two-entry output queue that decouples the result side from the pipeline.
module mf3_out_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mf3_pkg::out_item_t  push_item,
    input  logic                pop,
    output mf3_pkg::out_item_t  head,
    output logic                not_empty,
    output logic                full
);

    mf3_pkg::out_item_t ent0_reg, ent1_reg;
    logic [1:0]         cnt_reg, cnt_next;

    assign head      = ent0_reg;
    assign not_empty = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);

    // Occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Shift on pop, fill the first free slot on push
    always_ff @(posedge aclk) begin
        if (pop) begin
            ent0_reg <= (push && cnt_reg == 2'd1) ? push_item : ent1_reg;
        end else if (push && cnt_reg == 2'd0) begin
            ent0_reg <= push_item;
        end
        if (push && !pop && cnt_reg == 2'd1) begin
            ent1_reg <= push_item;
        end
    end

endmodule

// ----- hw/rtl/mf3_checker.sv -----
// Port-level checker of the 3x3 median filter and its bind to the top level.
`include "median_filter_3x3_unit_defines.svh"

module mf3_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            s_opcode,
    input logic [mf3_pkg::CHAN_W-1:0]      s_red,
    input logic [mf3_pkg::CHAN_W-1:0]      s_green,
    input logic [mf3_pkg::CHAN_W-1:0]      s_blue,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [mf3_pkg::CHAN_W-1:0]      m_out_red,
    input logic [mf3_pkg::CHAN_W-1:0]      m_out_green,
    input logic [mf3_pkg::CHAN_W-1:0]      m_out_blue,
    input logic                            m_end_of_frame,
    input logic                            cfg_wr_en,
    input logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    // The request side closes only when results are waiting
    `MF3_ASSERT_NOW(a_block_needs_result, !s_ready, m_valid, "request side closed with no result waiting")

    // A closed request side reopens only after a result is taken
    `MF3_ASSERT_NEXT(a_block_held, !s_ready && !m_ready, !s_ready, "request side reopened without a result taken")

    // A waiting result holds its value
    `MF3_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid && $stable({m_out_red, m_out_green, m_out_blue, m_end_of_frame}), "waiting result changed or vanished")

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (.*);

// ----- sim/tb_median_filter_3x3_unit.sv -----
// Self-checking testbench of the 3x3 median filter: raster frames, flushes and size changes.
module tb_median_filter_3x3_unit;
    import mf3_pkg::*;

    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 12;

    // Corner colors, primaries and a few mid values for the first frames
    localparam logic [23:0] DIRECTED_RGB [14] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h804020, 24'hFFFF00,
        24'h010203, 24'h00FFFF, 24'hC86432, 24'h070707, 24'h7F7F7F, 24'hFEFEFE, 24'h808080
    };

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic                   s_opcode       = OP_PIXEL;
    logic [CHAN_W-1:0]      s_red          = '0;
    logic [CHAN_W-1:0]      s_green        = '0;
    logic [CHAN_W-1:0]      s_blue         = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [CHAN_W-1:0]      m_out_red;
    logic [CHAN_W-1:0]      m_out_green;
    logic [CHAN_W-1:0]      m_out_blue;
    logic                   m_end_of_frame;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_wr_index   = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data    = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int unsigned n_taken       = 0;

    median_filter_3x3_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_red          (s_red),
        .s_green        (s_green),
        .s_blue         (s_blue),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue),
        .m_end_of_frame (m_end_of_frame),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_index   (cfg_wr_index),
        .cfg_wr_data    (cfg_wr_data)
    );

    // Tracks frame position, line stores and gray window; holds the pixels still due
    class median_window_track;
        logic [WIDTH_REG_W-1:0]  width_reg;
        logic [HEIGHT_REG_W-1:0] height_reg;
        pixel_t      upper_row [MAX_WIDTH];
        pixel_t      middle_row [MAX_WIDTH];
        gray_t       win [3][3];
        int unsigned in_col, out_col, out_row;
        pixel_t      pending_q [$];
        out_item_t   due_q [$];
        int unsigned err_cnt;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            err_cnt    = 0;
            foreach (upper_row[i]) begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            restart();
        endfunction

        // Clear counters, window and pending pixels; line stores keep their contents
        function void restart();
            foreach (win[r, c]) win[r][c] = '0;
            in_col  = 0;
            out_col = 0;
            out_row = 0;
            pending_q.delete();
        endfunction

        function int unsigned frame_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned frame_h();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FRAME_WIDTH) begin
                width_reg = data[WIDTH_REG_W-1:0];
            end else begin
                height_reg = data[HEIGHT_REG_W-1:0];
            end
            restart();
        endfunction

        function gray_t to_gray(pixel_t p);
            int unsigned sum;
            sum = 11 * p.red + 16 * p.green + 5 * p.blue;
            return gray_t'(sum >> 5);
        endfunction

        // Emit one pixel: median gray when filtered at an interior position, the pixel itself elsewhere
        function void queue_result(pixel_t px, bit filtered);
            int unsigned w, h, below, same;
            gray_t       taps [9];
            out_item_t   item;
            w = frame_w();
            h = frame_h();
            item.pix = px;
            item.eof = (out_row == h - 1) && (out_col == w - 1);
            if (filtered && w >= 3 && h >= 3 && out_row >= 1 && out_row <= h - 2 &&
                out_col >= 1 && out_col <= w - 2) begin
                foreach (win[r, c]) taps[r * 3 + c] = win[r][c];
                // pick the tap with at most four smaller values and five or more not larger
                foreach (taps[i]) begin
                    below = 0;
                    same  = 0;
                    foreach (taps[j]) begin
                        if (taps[j] < taps[i]) below++;
                        else if (taps[j] == taps[i]) same++;
                    end
                    if (below <= 4 && below + same > 4) item.pix = '{taps[i], taps[i], taps[i]};
                end
            end
            due_q.push_back(item);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) out_row = 0;
            end
        endfunction

        // Note one accepted request; returns 0 for a flush with nothing pending
        function bit on_request(opcode_t op, pixel_t px);
            int unsigned w, col;
            bit          release_old;
            w   = frame_w();
            col = (in_col >= w) ? 0 : in_col;
            if (op == OP_FLUSH) begin
                if (pending_q.size() == 0) return 1'b0;
                queue_result(pending_q.pop_front(), 1'b0);
                return 1'b1;
            end
            release_old = pending_q.size() >= w + 1;
            // shift the window left and load the new column from the line stores
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = to_gray(upper_row[col]);
            win[1][2] = to_gray(middle_row[col]);
            win[2][2] = to_gray(px);
            upper_row[col]  = middle_row[col];
            middle_row[col] = px;
            pending_q.push_back(px);
            in_col = (col + 1 >= w) ? 0 : col + 1;
            if (release_old) queue_result(pending_q.pop_front(), 1'b1);
            return 1'b1;
        endfunction

        function void check_result(input logic [CHAN_W-1:0] r, g, b, input logic eof);
            out_item_t want;
            if (due_q.size() == 0) begin
                $error("result with no pixel due: %0d %0d %0d eof %0b", r, g, b, eof);
                err_cnt++;
                return;
            end
            want = due_q.pop_front();
            if (r !== want.pix.red) begin
                $error("out_red: expected %0d, got %0d", want.pix.red, r);
                err_cnt++;
            end
            if (g !== want.pix.green) begin
                $error("out_green: expected %0d, got %0d", want.pix.green, g);
                err_cnt++;
            end
            if (b !== want.pix.blue) begin
                $error("out_blue: expected %0d, got %0d", want.pix.blue, b);
                err_cnt++;
            end
            if (eof !== want.eof) begin
                $error("end_of_frame: expected %0b, got %0b", want.eof, eof);
                err_cnt++;
            end
        endfunction
    endclass

    median_window_track trk = new();

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Drive result ready: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Check every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            trk.check_result(m_out_red, m_out_green, m_out_blue, m_end_of_frame);
    end

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = 24'($urandom);
        if ($urandom_range(7) == 0) p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(7) == 0) p.green = $urandom_range(1) ? 8'hFF : 8'h00;
        if ($urandom_range(7) == 0) p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        return p;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic offer(input opcode_t op, input pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_red    <= px.red;
        s_green  <= px.green;
        s_blue   <= px.blue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (trk.on_request(op, px)) n_taken++;
    endtask

    // Write a register once all due pixels are out and the pipeline is empty
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (trk.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        trk.set_reg(idx, data);
        cfg_wr_en <= 1'b0;
    endtask

    // Flush until no pixel is pending
    task automatic drain();
        while (trk.pending_q.size() != 0) offer(OP_FLUSH, random_pixel());
    endtask

    // One random frame size, whole frames back to back, then an optional broken tail
    task automatic run_frames();
        int unsigned           pick, n_pix;
        logic [CFG_DATA_W-1:0] w_data, h_data;
        pick   = $urandom_range(99);
        w_data = (pick < 6) ? '0 : CFG_DATA_W'($urandom_range(1, 9));
        // stray bits above the width register must be dropped
        w_data[CFG_DATA_W-1:WIDTH_REG_W] = 2'($urandom_range(3));
        h_data = (pick >= 94) ? '0 : CFG_DATA_W'($urandom_range(1, 7));
        case ($urandom_range(3))
            0: write_reg(CFG_FRAME_WIDTH, w_data);
            1: write_reg(CFG_FRAME_HEIGHT, h_data);
            default: begin
                write_reg(CFG_FRAME_WIDTH, w_data);
                write_reg(CFG_FRAME_HEIGHT, h_data);
            end
        endcase
        n_pix = $urandom_range(1, 3) * trk.frame_w() * trk.frame_h();
        repeat (n_pix) begin
            if ($urandom_range(99) < 3) offer(OP_FLUSH, random_pixel());
            offer(OP_PIXEL, random_pixel());
        end
        pick = $urandom_range(99);
        if (pick < 25) repeat ($urandom_range(1, 2 * trk.frame_w())) offer(OP_PIXEL, random_pixel());
        if (pick < 75) drain();
    endtask

    initial begin
        send_idle_pct = 26;
        recv_idle_pct = 82;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // 3x3 frame: empty flush, one full frame, start of the next, early flushes
        write_reg(CFG_FRAME_WIDTH, 13'd3);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        offer(OP_FLUSH, '0);
        for (int i = 0; i < 11; i++) offer(OP_PIXEL, DIRECTED_RGB[i]);
        offer(OP_FLUSH, '1);
        offer(OP_FLUSH, '0);
        for (int i = 11; i < 14; i++) offer(OP_PIXEL, DIRECTED_RGB[i]);
        drain();
        offer(OP_FLUSH, '1);

        n_taken = 0;
        while (n_taken < 180) run_frames();
        send_idle_pct = 82;
        recv_idle_pct = 26;
        while (n_taken < 360) run_frames();
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Hold the result side while requests keep coming until the input stalls
        write_reg(CFG_FRAME_WIDTH, 13'd4);
        write_reg(CFG_FRAME_HEIGHT, 13'd6);
        for (int i = 0; i < 60; i++) begin
            if (i == 10) hold_req = 1'b1;
            offer(OP_PIXEL, random_pixel());
        end
        drain();
        while (n_taken < 550) run_frames();

        // Widest rows: width above the line store depth, then exactly at it
        write_reg(CFG_FRAME_WIDTH, '1);
        write_reg(CFG_FRAME_HEIGHT, '1);
        repeat (MAX_WIDTH + 6) offer(OP_PIXEL, random_pixel());
        write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        write_reg(CFG_FRAME_HEIGHT, 13'd4096);
        repeat (MAX_WIDTH + 6) offer(OP_PIXEL, random_pixel());
        drain();

        s_valid <= 1'b0;
        while (trk.due_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (trk.err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- median_filter_3x3_unit.f -----
+incdir+hw/rtl
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_line_ram.sv
hw/rtl/mf3_median9.sv
hw/rtl/mf3_out_queue.sv
hw/rtl/median_filter_3x3_unit.sv
hw/rtl/mf3_checker.sv
sim/tb_median_filter_3x3_unit.sv
